[sv/lms_pkg.sv]
`default_nettype none

package lms_pkg;

    localparam int CountWidth = 32;
    localparam int TimeWidth  = 10;
    localparam int LineWidth  = 8;
    localparam int ModeWidth  = 2;
    localparam int EnWidth    = 3;
    localparam int IdxWidth   = 3;
    localparam int CfgWidth   = 10;

    // display modes as seen on the output
    localparam logic [ModeWidth-1:0] MODE_HBLANK   = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_VBLANK   = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_OAM      = 2'd2;
    localparam logic [ModeWidth-1:0] MODE_TRANSFER = 2'd3;

    // stat enable bits
    localparam int EN_HBLANK_BIT = 0;
    localparam int EN_VBLANK_BIT = 1;
    localparam int EN_OAM_BIT    = 2;

    // register indexes
    localparam logic [IdxWidth-1:0] REG_OAM_CYCLES      = 3'd0;
    localparam logic [IdxWidth-1:0] REG_TRANSFER_CYCLES = 3'd1;
    localparam logic [IdxWidth-1:0] REG_HBLANK_CYCLES   = 3'd2;
    localparam logic [IdxWidth-1:0] REG_VBLANK_CYCLES   = 3'd3;
    localparam logic [IdxWidth-1:0] REG_VBLANK_FIRST    = 3'd4;
    localparam logic [IdxWidth-1:0] REG_FRAME_LAST      = 3'd5;
    localparam logic [IdxWidth-1:0] REG_STAT_ENABLES    = 3'd6;

    typedef struct packed {
        logic [TimeWidth-1:0] oam_cycles;
        logic [TimeWidth-1:0] transfer_cycles;
        logic [TimeWidth-1:0] hblank_cycles;
        logic [TimeWidth-1:0] vblank_line_cycles;
        logic [LineWidth-1:0] vblank_first_line;
        logic [LineWidth-1:0] frame_last_line;
        logic [EnWidth-1:0]   stat_enables;
    } t_cfg;

    typedef struct packed {
        logic [ModeWidth-1:0] mode;
        logic [LineWidth-1:0] line;
        logic                 line_advanced;
        logic                 stat_interrupt;
    } t_result;

endpackage

`default_nettype wire

[sv/lcd_mode_timing_sequencer.sv]
// channel   handshake               payload
// in        i_in_valid/o_in_ready   i_cycle_count
// out       o_out_valid/i_out_ready o_mode, o_line, o_line_advanced, o_stat_interrupt
// cfg       i_cfg_we                i_cfg_index, i_cfg_data
//
// one beat per cycle sustained while the output is not stalled; an input beat passes
// through the input register, then the mode step into the result register
// the mode step is one add of the count, one compare and one subtract
// synchronous active-low reset restores the register defaults, mode hblank, line 0
// a stalled output holds the input register; new beats enter as the output drains
`default_nettype none

module lcd_mode_timing_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [lms_pkg::CountWidth-1:0] i_cycle_count,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [lms_pkg::ModeWidth-1:0]  o_mode,
    output      logic [lms_pkg::LineWidth-1:0]  o_line,
    output      logic                           o_line_advanced,
    output      logic                           o_stat_interrupt,
    input  wire logic                           i_cfg_we,
    input  wire logic [lms_pkg::IdxWidth-1:0]   i_cfg_index,
    input  wire logic [lms_pkg::CfgWidth-1:0]   i_cfg_data
);

    lms_pkg::t_cfg                  cfg;
    lms_pkg::t_result               step_res;
    logic                           r_in_valid;
    logic [lms_pkg::CountWidth-1:0] r_in_count;
    logic                           r_out_valid;
    lms_pkg::t_result               r_out;
    logic                           step;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    lms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_count  (r_in_count),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_count <= i_cycle_count;
        end
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_out.mode;
    assign o_line           = r_out.line;
    assign o_line_advanced  = r_out.line_advanced;
    assign o_stat_interrupt = r_out.stat_interrupt;

endmodule

`default_nettype wire

[sv/lms_cfg.sv]
`default_nettype none

module lms_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lms_pkg::IdxWidth-1:0]   i_cfg_index,
    input  wire logic [lms_pkg::CfgWidth-1:0]   i_cfg_data,
    output lms_pkg::t_cfg                       o_cfg
);

    lms_pkg::t_cfg r_cfg;
    lms_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                lms_pkg::REG_OAM_CYCLES:      n_cfg.oam_cycles         = i_cfg_data;
                lms_pkg::REG_TRANSFER_CYCLES: n_cfg.transfer_cycles    = i_cfg_data;
                lms_pkg::REG_HBLANK_CYCLES:   n_cfg.hblank_cycles      = i_cfg_data;
                lms_pkg::REG_VBLANK_CYCLES:   n_cfg.vblank_line_cycles = i_cfg_data;
                lms_pkg::REG_VBLANK_FIRST:
                    n_cfg.vblank_first_line = i_cfg_data[lms_pkg::LineWidth-1:0];
                lms_pkg::REG_FRAME_LAST:
                    n_cfg.frame_last_line = i_cfg_data[lms_pkg::LineWidth-1:0];
                lms_pkg::REG_STAT_ENABLES:
                    n_cfg.stat_enables = i_cfg_data[lms_pkg::EnWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oam_cycles         <= 10'd80;
            r_cfg.transfer_cycles    <= 10'd172;
            r_cfg.hblank_cycles      <= 10'd204;
            r_cfg.vblank_line_cycles <= 10'd456;
            r_cfg.vblank_first_line  <= 8'd144;
            r_cfg.frame_last_line    <= 8'd153;
            r_cfg.stat_enables       <= 3'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/lms_core.sv]
`default_nettype none

module lms_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [lms_pkg::CountWidth-1:0] i_count,
    input  wire lms_pkg::t_cfg                  i_cfg,
    output lms_pkg::t_result                    o_result
);

    // r_base holds accumulator minus previous count, so the elapsed add and
    // the accumulate fold into one add with the new count
    logic [lms_pkg::CountWidth-1:0] r_base;
    logic [lms_pkg::CountWidth-1:0] n_base;
    logic [lms_pkg::ModeWidth-1:0]  r_mode;
    logic [lms_pkg::ModeWidth-1:0]  n_mode;
    logic [lms_pkg::LineWidth-1:0]  r_line;
    logic [lms_pkg::LineWidth-1:0]  n_line;

    logic [lms_pkg::CountWidth-1:0] acc;
    logic [lms_pkg::TimeWidth-1:0]  thr;
    logic                           done;
    logic [lms_pkg::LineWidth-1:0]  line_inc;
    logic [lms_pkg::LineWidth:0]    line_wide;
    logic                           adv;
    logic                           irq;

    assign acc       = r_base + i_count;
    assign line_inc  = r_line + 8'd1;
    assign line_wide = {1'b0, r_line} + 9'd1;

    always_comb begin
        case (r_mode)
            lms_pkg::MODE_HBLANK: thr = i_cfg.hblank_cycles;
            lms_pkg::MODE_VBLANK: thr = i_cfg.vblank_line_cycles;
            lms_pkg::MODE_OAM:    thr = i_cfg.oam_cycles;
            default:              thr = i_cfg.transfer_cycles;
        endcase
    end

    assign done = (acc[lms_pkg::CountWidth-1:lms_pkg::TimeWidth] != '0)
                || (acc[lms_pkg::TimeWidth-1:0] >= thr);

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        adv    = 1'b0;
        irq    = 1'b0;
        if (done) begin
            case (r_mode)
                lms_pkg::MODE_HBLANK: begin
                    n_line = line_inc;
                    adv    = 1'b1;
                    if (line_inc == i_cfg.vblank_first_line) begin
                        n_mode = lms_pkg::MODE_VBLANK;
                        irq    = i_cfg.stat_enables[lms_pkg::EN_VBLANK_BIT]
                              || i_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                    end else begin
                        n_mode = lms_pkg::MODE_OAM;
                        irq    = i_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                    end
                end
                lms_pkg::MODE_VBLANK: begin
                    adv = 1'b1;
                    // compared at 9 bits so line 255 also wraps
                    if (line_wide > {1'b0, i_cfg.frame_last_line}) begin
                        n_line = '0;
                        n_mode = lms_pkg::MODE_OAM;
                        irq    = i_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                    end else begin
                        n_line = line_wide[lms_pkg::LineWidth-1:0];
                    end
                end
                lms_pkg::MODE_OAM: begin
                    n_mode = lms_pkg::MODE_TRANSFER;
                end
                default: begin
                    n_mode = lms_pkg::MODE_HBLANK;
                    irq    = i_cfg.stat_enables[lms_pkg::EN_HBLANK_BIT];
                end
            endcase
        end
    end

    assign n_base = done ? (r_base - {{(lms_pkg::CountWidth-lms_pkg::TimeWidth){1'b0}}, thr})
                         : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_mode <= lms_pkg::MODE_HBLANK;
            r_line <= '0;
        end else if (i_step) begin
            r_base <= n_base;
            r_mode <= n_mode;
            r_line <= n_line;
        end
    end

    assign o_result.mode           = n_mode;
    assign o_result.line           = n_line;
    assign o_result.line_advanced  = adv;
    assign o_result.stat_interrupt = irq;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int MAX_REPORTS     = 50;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 175;
    localparam int LONG_PHASE_BEATS = 300;
    localparam int SEND_IDLE_PCT[4]  = '{0, 66, 0, 25};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 66, 25};

    // index past the end of the register map, writes must be dropped
    localparam logic [lms_pkg::IdxWidth-1:0] REG_UNMAPPED = 3'd7;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [lms_pkg::CountWidth-1:0] i_cycle_count;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [lms_pkg::ModeWidth-1:0]  o_mode;
    logic [lms_pkg::LineWidth-1:0]  o_line;
    logic                           o_line_advanced;
    logic                           o_stat_interrupt;
    logic                           i_cfg_we;
    logic [lms_pkg::IdxWidth-1:0]   i_cfg_index;
    logic [lms_pkg::CfgWidth-1:0]   i_cfg_data;

    lcd_mode_timing_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cycle_count    (i_cycle_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mode           (o_mode),
        .o_line           (o_line),
        .o_line_advanced  (o_line_advanced),
        .o_stat_interrupt (o_stat_interrupt),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // timing state mirrored on the testbench side
    lms_pkg::t_cfg                  timing_cfg;
    logic [lms_pkg::ModeWidth-1:0]  timing_mode;
    logic [lms_pkg::LineWidth-1:0]  timing_line;
    logic [lms_pkg::CountWidth-1:0] timing_acc;
    logic [lms_pkg::CountWidth-1:0] timing_prev;

    lms_pkg::t_result expected_status_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int results_seen;
    int counts_sent;
    int settings_used;
    int frame_wraps;
    int stat_requests;
    int cycle_count;

    function automatic lms_pkg::t_result advance_timing(
        input logic [lms_pkg::CountWidth-1:0] now);
        lms_pkg::t_result              r;
        logic [lms_pkg::LineWidth:0]   next_line;
        r = '0;
        timing_acc  = timing_acc + (now - timing_prev);
        timing_prev = now;
        case (timing_mode)
            lms_pkg::MODE_HBLANK: if (timing_acc >= timing_cfg.hblank_cycles) begin
                timing_line = timing_line + 8'd1;
                if (timing_line == timing_cfg.vblank_first_line) begin
                    timing_mode = lms_pkg::MODE_VBLANK;
                    // vblank entry also fires on the oam enable
                    r.stat_interrupt = timing_cfg.stat_enables[lms_pkg::EN_VBLANK_BIT]
                                     | timing_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                end else begin
                    timing_mode      = lms_pkg::MODE_OAM;
                    r.stat_interrupt = timing_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                end
                timing_acc      = timing_acc - timing_cfg.hblank_cycles;
                r.line_advanced = 1'b1;
            end
            lms_pkg::MODE_VBLANK: if (timing_acc >= timing_cfg.vblank_line_cycles) begin
                next_line = {1'b0, timing_line} + 9'd1;
                if (next_line > {1'b0, timing_cfg.frame_last_line}) begin
                    timing_line      = '0;
                    timing_mode      = lms_pkg::MODE_OAM;
                    r.stat_interrupt = timing_cfg.stat_enables[lms_pkg::EN_OAM_BIT];
                    frame_wraps++;
                end else begin
                    timing_line = next_line[lms_pkg::LineWidth-1:0];
                end
                timing_acc      = timing_acc - timing_cfg.vblank_line_cycles;
                r.line_advanced = 1'b1;
            end
            lms_pkg::MODE_OAM: if (timing_acc >= timing_cfg.oam_cycles) begin
                timing_mode = lms_pkg::MODE_TRANSFER;
                timing_acc  = timing_acc - timing_cfg.oam_cycles;
            end
            default: if (timing_acc >= timing_cfg.transfer_cycles) begin
                timing_mode      = lms_pkg::MODE_HBLANK;
                r.stat_interrupt = timing_cfg.stat_enables[lms_pkg::EN_HBLANK_BIT];
                timing_acc       = timing_acc - timing_cfg.transfer_cycles;
            end
        endcase
        r.mode = timing_mode;
        r.line = timing_line;
        if (r.stat_interrupt)
            stat_requests++;
        return r;
    endfunction

    // next counter value, steered by the mirrored accumulator so that
    // transitions keep happening; some jumps, wraps and backward steps mixed in
    function automatic logic [lms_pkg::CountWidth-1:0] pick_count();
        logic [lms_pkg::CountWidth-1:0] thr;
        logic [lms_pkg::CountWidth-1:0] target;
        int unsigned                    roll;
        case (timing_mode)
            lms_pkg::MODE_HBLANK: thr = 32'(timing_cfg.hblank_cycles);
            lms_pkg::MODE_VBLANK: thr = 32'(timing_cfg.vblank_line_cycles);
            lms_pkg::MODE_OAM:    thr = 32'(timing_cfg.oam_cycles);
            default:              thr = 32'(timing_cfg.transfer_cycles);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 4 || (timing_acc > 32'd4096 && roll < 50)) begin
            target = $urandom_range(0, thr + thr / 2);
            return timing_prev + target - timing_acc;
        end
        if (roll < 8)
            return $urandom();
        if (roll < 11)
            return timing_prev - $urandom_range(1, 64);
        return timing_prev + $urandom_range(thr / 2, thr + thr / 4 + 1);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                      results_seen, field, got, want));
    endtask

    task automatic send_count(input logic [lms_pkg::CountWidth-1:0] cnt);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cycle_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_status_q.push_back(advance_timing(cnt));
        counts_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lms_pkg::IdxWidth-1:0] idx,
                             input logic [lms_pkg::CfgWidth-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            lms_pkg::REG_OAM_CYCLES:      timing_cfg.oam_cycles         = data;
            lms_pkg::REG_TRANSFER_CYCLES: timing_cfg.transfer_cycles    = data;
            lms_pkg::REG_HBLANK_CYCLES:   timing_cfg.hblank_cycles      = data;
            lms_pkg::REG_VBLANK_CYCLES:   timing_cfg.vblank_line_cycles = data;
            lms_pkg::REG_VBLANK_FIRST:
                timing_cfg.vblank_first_line = data[lms_pkg::LineWidth-1:0];
            lms_pkg::REG_FRAME_LAST:
                timing_cfg.frame_last_line = data[lms_pkg::LineWidth-1:0];
            lms_pkg::REG_STAT_ENABLES:
                timing_cfg.stat_enables = data[lms_pkg::EnWidth-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure_timing(input int oam, input int xfer, input int hbl,
                                    input int vbl, input int first, input int last,
                                    input int en);
        write_reg(lms_pkg::REG_OAM_CYCLES, lms_pkg::CfgWidth'(oam));
        write_reg(lms_pkg::REG_TRANSFER_CYCLES, lms_pkg::CfgWidth'(xfer));
        write_reg(lms_pkg::REG_HBLANK_CYCLES, lms_pkg::CfgWidth'(hbl));
        write_reg(lms_pkg::REG_VBLANK_CYCLES, lms_pkg::CfgWidth'(vbl));
        write_reg(lms_pkg::REG_VBLANK_FIRST, lms_pkg::CfgWidth'(first));
        write_reg(lms_pkg::REG_FRAME_LAST, lms_pkg::CfgWidth'(last));
        write_reg(lms_pkg::REG_STAT_ENABLES, lms_pkg::CfgWidth'(en));
        settings_used++;
    endtask

    // reset values: one short of the hblank length, then exactly on it
    task automatic test_default_timing();
        send_count(32'd0);
        send_count(32'd203);
        send_count(32'd204);
        wait_idle();
    endtask

    // zero lengths step once per beat through a whole four-line frame;
    // only the vblank enable is set, counts jump across the full range
    task automatic test_walk_vblank_enable();
        logic [lms_pkg::CountWidth-1:0] corner_counts[8];
        corner_counts = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h0000_0001};
        configure_timing(0, 0, 0, 0, 2, 3, 2);
        write_reg(REG_UNMAPPED, 10'h3FF);
        foreach (corner_counts[k])
            send_count(corner_counts[k]);
        wait_idle();
    endtask

    // same frame again with only the oam enable, which covers vblank entry too
    task automatic test_walk_oam_enable();
        write_reg(lms_pkg::REG_STAT_ENABLES, 10'b00_0000_0100);
        repeat (8) send_count(timing_prev);
        wait_idle();
    endtask

    // longest lengths: one below, exactly on, a full length, then nothing
    task automatic test_max_thresholds();
        configure_timing(1023, 1023, 1023, 1023, 254, 255, 1);
        send_count(timing_prev + (32'd1022 - timing_acc));
        send_count(timing_prev + 32'd1);
        send_count(timing_prev + 32'd1023);
        send_count(timing_prev);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int   beats;
        int   hi;
        logic [lms_pkg::LineWidth-1:0] first;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            beats = PHASE_BEATS;
            hi    = ($urandom_range(0, 3) == 0) ? 1023 : 40;
            case (p)
                1: configure_timing(1, 1, 1, 1, 1, 1, $urandom_range(0, 7));
                3: configure_timing(1023, 1023, 1023, 1023, 254, 255, 7);
                5: begin
                    // vblank from the next line on, all the way up to line 255
                    first = timing_line + 8'd1;
                    if (first == 8'd0 || first == 8'd255)
                        first = 8'd1;
                    configure_timing($urandom_range(1, 8), $urandom_range(1, 8),
                                     $urandom_range(1, 8), 0, int'(first), 255,
                                     $urandom_range(0, 7));
                    beats = LONG_PHASE_BEATS;
                end
                default: configure_timing($urandom_range(1, hi), $urandom_range(1, hi),
                                          $urandom_range(1, hi), $urandom_range(1, hi),
                                          $urandom_range(1, 10), $urandom_range(1, 14),
                                          $urandom_range(0, 7));
            endcase
            send_idle_pct  = SEND_IDLE_PCT[p % 4];
            recv_stall_pct = RECV_STALL_PCT[p % 4];
            for (int k = 0; k < beats; k++) begin
                if (p == 2 && k == beats / 2)
                    wait_idle();
                send_count(pick_count());
            end
            wait_idle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        lms_pkg::t_result got;
        lms_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.mode           = o_mode;
            got.line           = o_line;
            got.line_advanced  = o_line_advanced;
            got.stat_interrupt = o_stat_interrupt;
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("beat %0d with nothing pending: mode %0d line %0d",
                                          results_seen, got.mode, got.line));
            end else begin
                want = expected_status_q.pop_front();
                compare_field("mode", 8'(got.mode), 8'(want.mode));
                compare_field("line", got.line, want.line);
                compare_field("line_advanced", 8'(got.line_advanced),
                              8'(want.line_advanced));
                compare_field("stat_interrupt", 8'(got.stat_interrupt),
                              8'(want.stat_interrupt));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats pending",
                     cycle_count, expected_status_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cycle_count  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        results_seen   = 0;
        counts_sent    = 0;
        settings_used  = 1;
        frame_wraps    = 0;
        stat_requests  = 0;
        cycle_count    = 0;

        timing_cfg.oam_cycles         = 10'd80;
        timing_cfg.transfer_cycles    = 10'd172;
        timing_cfg.hblank_cycles      = 10'd204;
        timing_cfg.vblank_line_cycles = 10'd456;
        timing_cfg.vblank_first_line  = 8'd144;
        timing_cfg.frame_last_line    = 8'd153;
        timing_cfg.stat_enables       = '0;
        timing_mode = lms_pkg::MODE_HBLANK;
        timing_line = '0;
        timing_acc  = '0;
        timing_prev = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_walk_vblank_enable();
        test_walk_oam_enable();
        test_max_thresholds();
        test_random_traffic();
        wait_idle();

        $display("covered %0d cycle counts under %0d timing settings, %0d beats checked",
                 counts_sent, settings_used, results_seen);
        $display("frames wrapped %0d times, %0d stat requests expected",
                 frame_wraps, stat_requests);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
